// ===== sv/tatu_pkg.sv =====
// Package for the tick accounting and timeout unit.
// Holds request, interrupt action and register index codes, reset values,
// the controller state type and the controller/datapath interface structs.
package tatu_pkg;

	// default counter width handed to the top level
	localparam int DEF_COUNTER_WIDTH = 32;

	// request type codes
	localparam logic [1:0] REQ_COMPARE = 2'd0;
	localparam logic [1:0] REQ_TIMEOUT = 2'd1;
	localparam logic [1:0] REQ_ELAPSED = 2'd2;

	// interrupt action codes
	localparam logic [1:0] IRQ_NONE   = 2'd0;
	localparam logic [1:0] IRQ_UNMASK = 2'd1;
	localparam logic [1:0] IRQ_MASK   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_CYCLES_PER_TICK = 2'd0;
	localparam logic [1:0] CFG_CYCLES_MAX      = 2'd1;
	localparam logic [1:0] CFG_TICKLESS_MODE   = 2'd2;

	// configuration reset values
	localparam logic [31:0] RST_CYCLES_PER_TICK = 32'd1;
	localparam logic [31:0] RST_CYCLES_MAX      = 32'd3221225472;
	localparam logic        RST_TICKLESS_MODE   = 1'b1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture request, seed divider
		logic div_step;  // one restoring division step
		logic mul;       // register the timeout product
		logic finish;    // write result and update tick state
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic tickless;  // tickless mode register
		logic out_free;  // output register can take a result this cycle
	} ctl_sts_t;

endpackage

// ===== sv/tatu_ctrl.sv =====
// Controller state machine for the tick accounting and timeout unit.
// Sequences capture, bit-serial division, product and result write.
// Depends on tatu_pkg.
module tatu_ctrl #(
	parameter int COUNTER_WIDTH = tatu_pkg::DEF_COUNTER_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  tatu_pkg::ctl_sts_t  sts,
	output tatu_pkg::ctl_cmd_t  cmd
);
	import tatu_pkg::*;

	localparam int CYC_W  = (COUNTER_WIDTH < 32) ? COUNTER_WIDTH : 32;
	localparam int STEP_W = $clog2(CYC_W);

	state_t              state_q, state_nxt;
	logic [STEP_W-1:0]   step_q;
	logic                div_last;

	assign div_last = (step_q == STEP_W'(CYC_W - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (req_type == REQ_COMPARE) begin
						state_nxt = ST_DIV;
					end else if (req_type == REQ_ELAPSED) begin
						state_nxt = sts.tickless ? ST_DIV : ST_FIN;
					end else if (req_type == REQ_TIMEOUT) begin
						state_nxt = ST_MUL;
					end else begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_MUL: begin
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul      = (state_q == ST_MUL);
		cmd.finish   = (state_q == ST_FIN) && sts.out_free;
	end

endmodule

// ===== sv/tatu_dpath.sv =====
// Datapath for the tick accounting and timeout unit: configuration,
// tick state, restoring divider, timeout multiplier and output register.
// Depends on tatu_pkg; driven by tatu_ctrl commands.
module tatu_dpath #(
	parameter int COUNTER_WIDTH = tatu_pkg::DEF_COUNTER_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tatu_pkg::ctl_cmd_t  cmd,
	output tatu_pkg::ctl_sts_t  sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [1:0]          req_type,
	input  logic [31:0]         counter_value,
	input  logic signed [31:0]  timeout_ticks,
	input  logic                idle_flag,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                compare_valid,
	output logic [31:0]         compare_value,
	output logic                announce_valid,
	output logic [31:0]         tick_count_out,
	output logic [1:0]          irq_action
);
	import tatu_pkg::*;

	// cycle arithmetic width: counter width, limited to 32 bits
	localparam int CYC_W = (COUNTER_WIDTH < 32) ? COUNTER_WIDTH : 32;

	logic [31:0]        cpt_q, cmax_q;
	logic               tickless_q;
	logic [1:0]         req_q;
	logic [CYC_W-1:0]   ctr_q;
	logic [31:0]        tmo_q;
	logic               idle_q;
	logic [CYC_W-1:0]   ac_q;
	logic [31:0]        at_q, ets_q;
	logic [32:0]        rem_q;
	logic [CYC_W-1:0]   quo_q;
	logic [CYC_W-1:0]   prod_q;
	logic               out_valid_q;

	logic [31:0]        div;
	logic [32:0]        rem_sh;
	logic               rem_ge;
	logic [31:0]        tick_sum;

	// result and state update of the finishing request
	logic               r_cv, r_av;
	logic [31:0]        r_cval, r_tco;
	logic [1:0]         r_irq;
	logic               upd_cmp, upd_ets;
	logic [CYC_W-1:0]   ac_new, clamp_v, cyc_dist, next_v;
	logic               forever_t, over;

	// zero cycles per tick divides as one
	assign div = (cpt_q == 32'd0) ? 32'd1 : cpt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpt_q      <= RST_CYCLES_PER_TICK;
			cmax_q     <= RST_CYCLES_MAX;
			tickless_q <= RST_TICKLESS_MODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CYCLES_PER_TICK: cpt_q      <= cfg_data;
				CFG_CYCLES_MAX:      cmax_q     <= cfg_data;
				CFG_TICKLESS_MODE:   tickless_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			ctr_q  <= CYC_W'(counter_value);
			tmo_q  <= $unsigned(timeout_ticks);
			idle_q <= idle_flag;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q[31:0], quo_q[CYC_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, div});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= CYC_W'(counter_value) - ac_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, div}) : rem_sh;
			quo_q <= {quo_q[CYC_W-2:0], rem_ge};
		end
	end

	// timeout target: (ticks announced + elapsed + requested) * cycles per tick
	assign tick_sum = at_q + ets_q + tmo_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= CYC_W'(tick_sum * cpt_q);
		end
	end

	// result of the current request
	always_comb begin
		r_cv      = 1'b0;
		r_cval    = '0;
		r_av      = 1'b0;
		r_tco     = '0;
		r_irq     = IRQ_NONE;
		upd_cmp   = 1'b0;
		upd_ets   = 1'b0;
		// announce lands on the last whole tick boundary
		ac_new    = ctr_q - CYC_W'(rem_q);
		clamp_v   = ac_q + CYC_W'(cmax_q);
		cyc_dist  = prod_q - ac_q;
		over      = (32'(cyc_dist) > cmax_q);
		forever_t = (tmo_q == 32'hFFFF_FFFF);
		next_v    = (forever_t || over) ? clamp_v : prod_q;
		unique case (req_q)
			REQ_COMPARE: begin
				upd_cmp = 1'b1;
				r_av    = 1'b1;
				r_tco   = 32'(quo_q);
				if (tickless_q) begin
					r_irq = IRQ_MASK;
				end else begin
					r_cv   = 1'b1;
					r_cval = 32'(ac_new + CYC_W'(div));
				end
			end
			REQ_TIMEOUT: begin
				if (tickless_q && !(idle_q && forever_t)) begin
					r_cv   = 1'b1;
					r_cval = 32'(next_v);
					r_irq  = IRQ_UNMASK;
				end
			end
			REQ_ELAPSED: begin
				if (tickless_q) begin
					upd_ets = 1'b1;
					r_tco   = 32'(quo_q);
				end
			end
			default: ;
		endcase
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_q  <= '0;
			at_q  <= '0;
			ets_q <= '0;
		end else if (cmd.finish) begin
			if (upd_cmp) begin
				ac_q  <= ac_new;
				at_q  <= at_q + 32'(quo_q);
				ets_q <= '0;
			end else if (upd_ets) begin
				ets_q <= 32'(quo_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			compare_valid  <= r_cv;
			compare_value  <= r_cval;
			announce_valid <= r_av;
			tick_count_out <= r_tco;
			irq_action     <= r_irq;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.tickless = tickless_q;

endmodule

// ===== sv/tick_accounting_timeout_unit.sv =====
// Tick accounting and timeout unit, one request at a time.
// Compare event or tickless elapsed query: the request passes through the
// restoring divider (one quotient bit per cycle, CW = min(COUNTER_WIDTH,32)),
// then the result write. Set timeout: one multiply state, then the result
// write. Other requests go straight to the result write. A new request is taken only once the result is written.
// Reset clears the tick state and loads register defaults; no clearing pass.
module tick_accounting_timeout_unit #(
	parameter int COUNTER_WIDTH = tatu_pkg::DEF_COUNTER_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [31:0]        counter_value,
	input  logic signed [31:0] timeout_ticks,
	input  logic               idle_flag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               compare_valid,
	output logic [31:0]        compare_value,
	output logic               announce_valid,
	output logic [31:0]        tick_count_out,
	output logic [1:0]         irq_action
);
	import tatu_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencer
	tatu_ctrl #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, state and output register
	tatu_dpath #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.counter_value  (counter_value),
		.timeout_ticks  (timeout_ticks),
		.idle_flag      (idle_flag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.compare_valid  (compare_valid),
		.compare_value  (compare_value),
		.announce_valid (announce_valid),
		.tick_count_out (tick_count_out),
		.irq_action     (irq_action)
	);

endmodule

// ===== dv/tick_accounting_timeout_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tick_accounting_timeout_unit: directed table,
// then random phases. Depends on tatu_pkg (codes, reset values) and the unit's RTL.

module tick_accounting_timeout_unit_tb;
	import tatu_pkg::*;

	localparam int N_PHASES       = 6;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 40;

	// one request as driven on the input channel
	typedef struct packed {
		logic [1:0]  req;
		logic [31:0] counter;
		logic [31:0] tmo;
		logic        idle;
	} timer_req_t;

	// one reply as seen on the output channel
	typedef struct packed {
		logic        cmp_valid;
		logic [31:0] cmp_value;
		logic        ann_valid;
		logic [31:0] ticks;
		logic [1:0]  irq;
	} timer_reply_t;

	// directed table row: a register write or a request, with an optional typed-in reply
	typedef struct {
		bit           is_cfg;
		logic [1:0]   reg_idx;
		logic [31:0]  reg_val;
		timer_req_t   rq;
		bit           typed;
		timer_reply_t reply;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [31:0]        counter_value;
	logic signed [31:0] timeout_ticks;
	logic               idle_flag;
	logic               out_valid;
	logic               out_stall;
	logic               compare_valid;
	logic [31:0]        compare_value;
	logic               announce_valid;
	logic [31:0]        tick_count_out;
	logic [1:0]         irq_action;

	// shadow registers and tick state of the predictor
	logic [31:0] per_tick;
	logic [31:0] max_cycles;
	logic        tickless;
	logic [31:0] ann_cycle;
	logic [31:0] ann_tick;
	logic [31:0] elapsed_seen;

	timer_reply_t pending_replies[$];
	plan_row_t    plan[$];
	int unsigned  reqs_by_type[4];
	int unsigned  replies_checked;
	int unsigned  mismatches;
	bit           idling_on;
	bit           long_hold_req;

	tick_accounting_timeout_unit #(
		.COUNTER_WIDTH(32)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.counter_value (counter_value),
		.timeout_ticks (timeout_ticks),
		.idle_flag     (idle_flag),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.compare_valid (compare_valid),
		.compare_value (compare_value),
		.announce_valid(announce_valid),
		.tick_count_out(tick_count_out),
		.irq_action    (irq_action)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		#6000000;
		$display("FAIL");
		$finish;
	end

	// expected reply for one request; advances the shadow tick state
	function automatic timer_reply_t predict_timer_reply(input timer_req_t rq);
		timer_reply_t r;
		logic [31:0]  dv;
		logic [31:0]  dt;
		logic [31:0]  nxt;
		logic [31:0]  tick_sum;
		r = '0;
		dv = (per_tick == 32'd0) ? 32'd1 : per_tick;
		case (rq.req)
			REQ_COMPARE: begin
				dt = (rq.counter - ann_cycle) / dv;
				ann_cycle = ann_cycle + dt * dv;
				ann_tick = ann_tick + dt;
				elapsed_seen = 32'd0;
				if (!tickless) begin
					r.cmp_valid = 1'b1;
					r.cmp_value = ann_cycle + dv;
				end else begin
					r.irq = IRQ_MASK;
				end
				r.ann_valid = 1'b1;
				r.ticks = dt;
			end
			REQ_TIMEOUT: begin
				// idle with no deadline leaves the compare alone
				if (tickless && !(rq.idle && rq.tmo == 32'hFFFF_FFFF)) begin
					if (rq.tmo == 32'hFFFF_FFFF) begin
						nxt = ann_cycle + max_cycles;
					end else begin
						tick_sum = ann_tick + elapsed_seen + rq.tmo;
						nxt = tick_sum * per_tick;
						if ((nxt - ann_cycle) > max_cycles)
							nxt = ann_cycle + max_cycles;
					end
					r.cmp_valid = 1'b1;
					r.cmp_value = nxt;
					r.irq = IRQ_UNMASK;
				end
			end
			REQ_ELAPSED: begin
				if (tickless) begin
					dt = (rq.counter - ann_cycle) / dv;
					elapsed_seen = dt;
					r.ticks = dt;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
		plan_row_t p;
		p = '{default: '0};
		p.is_cfg = 1'b1;
		p.reg_idx = idx;
		p.reg_val = val;
		return p;
	endfunction

	function automatic plan_row_t req_row(input logic [1:0] req, input logic [31:0] cnt,
			input logic [31:0] tmo, input logic idle);
		plan_row_t p;
		p = '{default: '0};
		p.rq = '{req: req, counter: cnt, tmo: tmo, idle: idle};
		return p;
	endfunction

	function automatic plan_row_t req_row_exp(input logic [1:0] req, input logic [31:0] cnt,
			input logic [31:0] tmo, input logic idle, input logic cv, input logic [31:0] cval,
			input logic av, input logic [31:0] tco, input logic [1:0] irq);
		plan_row_t p;
		p = req_row(req, cnt, tmo, idle);
		p.typed = 1'b1;
		p.reply = '{cmp_valid: cv, cmp_value: cval, ann_valid: av, ticks: tco, irq: irq};
		return p;
	endfunction

	// register write, only once the unit has drained
	task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CYCLES_PER_TICK: per_tick = val;
			CFG_CYCLES_MAX:      max_cycles = val;
			CFG_TICKLESS_MODE:   tickless = val[0];
			default: ;
		endcase
	endtask

	// offer one request, with an optional gap first; returns at its transfer
	task automatic offer(input timer_req_t rq, input bit typed, input timer_reply_t typed_reply);
		timer_reply_t model_reply;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq.req;
		counter_value <= rq.counter;
		timeout_ticks <= rq.tmo;
		idle_flag <= rq.idle;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		model_reply = predict_timer_reply(rq);
		pending_replies.push_back(typed ? typed_reply : model_reply);
		reqs_by_type[rq.req]++;
	endtask

	task automatic match_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// output side: random stall bursts, quiet stretches, one long hold-off
	initial begin : receiver
		int unsigned r;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 9);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (idling_on && r < 2) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall <= 1'b0;
			end else if (r == 2) begin
				repeat ($urandom_range(30, 120)) @(negedge clk);
			end
		end
	end

	// reply check against the oldest expectation
	always @(posedge clk) begin : reply_monitor
		timer_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected none, got cv=%b cval=%h av=%b tco=%h irq=%0d",
					$time, compare_valid, compare_value, announce_valid, tick_count_out,
					irq_action);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				replies_checked++;
				match_field("compare_valid", 32'(want.cmp_valid), 32'(compare_valid));
				match_field("compare_value", want.cmp_value, compare_value);
				match_field("announce_valid", 32'(want.ann_valid), 32'(announce_valid));
				match_field("tick_count_out", want.ticks, tick_count_out);
				match_field("irq_action", 32'(want.irq), 32'(irq_action));
			end
		end
	end

	initial begin : stimulus
		timer_req_t   rq;
		timer_reply_t none;
		plan_row_t    row;
		logic [31:0]  wall;
		logic [31:0]  step;
		logic [31:0]  cmax_pick;
		int unsigned  kind;

		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CYCLES_PER_TICK;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		req_type = REQ_COMPARE;
		counter_value = 32'd0;
		timeout_ticks = 32'sd0;
		idle_flag = 1'b0;
		idling_on = 1'b1;
		long_hold_req = 1'b0;
		mismatches = 0;
		replies_checked = 0;
		none = '0;
		wall = 32'd0;

		per_tick = RST_CYCLES_PER_TICK;
		max_cycles = RST_CYCLES_MAX;
		tickless = RST_TICKLESS_MODE;
		ann_cycle = 32'd0;
		ann_tick = 32'd0;
		elapsed_seen = 32'd0;

		// directed table; reset config first: tickless, one cycle per tick
		plan.push_back(req_row_exp(REQ_ELAPSED, 32'd0, 32'd0, 1'b0,
			1'b0, 32'd0, 1'b0, 32'd0, IRQ_NONE));
		plan.push_back(req_row_exp(REQ_ELAPSED, 32'd100, 32'd0, 1'b0,
			1'b0, 32'd0, 1'b0, 32'd100, IRQ_NONE));
		plan.push_back(req_row_exp(REQ_TIMEOUT, 32'd0, 32'hFFFF_FFFF, 1'b1,
			1'b0, 32'd0, 1'b0, 32'd0, IRQ_NONE));
		plan.push_back(req_row_exp(REQ_TIMEOUT, 32'd0, 32'hFFFF_FFFF, 1'b0,
			1'b1, 32'hC000_0000, 1'b0, 32'd0, IRQ_UNMASK));
		plan.push_back(req_row_exp(REQ_TIMEOUT, 32'd0, 32'd5, 1'b0,
			1'b1, 32'd105, 1'b0, 32'd0, IRQ_UNMASK));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'h7FFF_FFFF, 1'b1));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'hFFFF_FFFE, 1'b0));
		// zero ticks elapsed still announces
		plan.push_back(req_row_exp(REQ_COMPARE, 32'd0, 32'd0, 1'b0,
			1'b0, 32'd0, 1'b1, 32'd0, IRQ_MASK));
		plan.push_back(req_row_exp(REQ_COMPARE, 32'hFFFF_FFFF, 32'd0, 1'b1,
			1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF, IRQ_MASK));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'd1, 1'b0));
		plan.push_back(req_row(REQ_ELAPSED, 32'h7FFF_FFFF, 32'd0, 1'b0));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'h4000_0000, 1'b0));
		// unused request code
		plan.push_back(req_row_exp(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			1'b0, 32'd0, 1'b0, 32'd0, IRQ_NONE));
		// periodic: timeout and query do nothing
		plan.push_back(cfg_row(CFG_TICKLESS_MODE, 32'd0));
		plan.push_back(cfg_row(CFG_CYCLES_PER_TICK, 32'd1000));
		plan.push_back(cfg_row(CFG_CYCLES_MAX, 32'd5000));
		plan.push_back(req_row_exp(REQ_TIMEOUT, 32'd0, 32'd3, 1'b0,
			1'b0, 32'd0, 1'b0, 32'd0, IRQ_NONE));
		plan.push_back(req_row_exp(REQ_ELAPSED, 32'd12345, 32'd0, 1'b0,
			1'b0, 32'd0, 1'b0, 32'd0, IRQ_NONE));
		plan.push_back(req_row(REQ_COMPARE, 32'h0000_1000, 32'd0, 1'b0));
		plan.push_back(req_row(REQ_COMPARE, 32'h0000_1000, 32'd0, 1'b0));
		// zero cycles per tick, smallest cycle limit
		plan.push_back(cfg_row(CFG_TICKLESS_MODE, 32'd1));
		plan.push_back(cfg_row(CFG_CYCLES_PER_TICK, 32'd0));
		plan.push_back(cfg_row(CFG_CYCLES_MAX, 32'd1));
		plan.push_back(req_row(REQ_COMPARE, 32'd500, 32'd0, 1'b0));
		plan.push_back(req_row(REQ_ELAPSED, 32'd900, 32'd0, 1'b1));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'd10, 1'b0));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'hFFFF_FFFF, 1'b0));
		// largest divisor and cycle limit
		plan.push_back(cfg_row(CFG_CYCLES_PER_TICK, 32'hFFFF_FFFF));
		plan.push_back(cfg_row(CFG_CYCLES_MAX, 32'hFFFF_FFFF));
		plan.push_back(req_row(REQ_COMPARE, 32'hFFFF_FFFE, 32'd0, 1'b0));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'd2, 1'b1));
		plan.push_back(req_row(REQ_ELAPSED, 32'd0, 32'd0, 1'b0));
		plan.push_back(req_row(REQ_TIMEOUT, 32'd0, 32'hFFFF_FFFB, 1'b0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg)
				program_reg(row.reg_idx, row.reg_val);
			else
				offer(row.rq, row.typed, row.reply);
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < N_PHASES; ph++) begin
			cmax_pick = $urandom;
			if (cmax_pick == 32'd0)
				cmax_pick = 32'd1;
			case (ph)
				0: begin
					program_reg(CFG_CYCLES_PER_TICK, $urandom_range(1, 1000));
					program_reg(CFG_CYCLES_MAX, cmax_pick);
					program_reg(CFG_TICKLESS_MODE, 32'd1);
				end
				1: begin
					program_reg(CFG_CYCLES_PER_TICK, 32'd1);
					program_reg(CFG_CYCLES_MAX, 32'hFFFF_FFFF);
				end
				2: begin
					program_reg(CFG_CYCLES_PER_TICK, $urandom);
					program_reg(CFG_CYCLES_MAX, $urandom_range(1, 100000));
				end
				3: begin
					program_reg(CFG_CYCLES_PER_TICK, $urandom_range(1, 5000));
					program_reg(CFG_CYCLES_MAX, cmax_pick);
					program_reg(CFG_TICKLESS_MODE, 32'd0);
				end
				4: begin
					program_reg(CFG_CYCLES_PER_TICK, 32'd0);
					program_reg(CFG_CYCLES_MAX, 32'd1);
					program_reg(CFG_TICKLESS_MODE, 32'd1);
				end
				default: begin
					program_reg(CFG_CYCLES_PER_TICK, $urandom_range(1, 300));
					program_reg(CFG_CYCLES_MAX, $urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
					program_reg(CFG_TICKLESS_MODE, $urandom_range(0, 1));
					// last stretch runs at full rate
					idling_on = 1'b0;
				end
			endcase

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 1 && n == 100)
					long_hold_req = 1'b1;
				if ($urandom_range(0, 9) < 2) begin
					// noise: any code, any counter, any timeout
					rq.req = 2'($urandom_range(0, 3));
					rq.counter = $urandom;
					rq.tmo = $urandom;
					rq.idle = 1'($urandom_range(0, 1));
				end else begin
					// a running counter, mostly a few ticks per event
					step = (per_tick == 32'd0) ? 32'd1 : per_tick;
					wall = wall + $urandom_range(0, 3) * step + $urandom_range(0, step - 32'd1);
					kind = $urandom_range(0, 9);
					rq.counter = wall;
					rq.idle = 1'($urandom_range(0, 1));
					rq.tmo = 32'd0;
					if (kind < 4) begin
						rq.req = REQ_COMPARE;
					end else if (kind < 7) begin
						rq.req = REQ_ELAPSED;
					end else begin
						rq.req = REQ_TIMEOUT;
						case ($urandom_range(0, 9))
							0:       rq.tmo = 32'hFFFF_FFFF;
							1:       rq.tmo = $urandom_range(0, 32'h7FFF_FFFF);
							default: rq.tmo = $urandom_range(0, 50);
						endcase
					end
				end
				offer(rq, 1'b0, none);
			end
		end

		// drain
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d replies: %0d compare events, %0d timeouts, %0d queries",
			replies_checked, reqs_by_type[0], reqs_by_type[1], reqs_by_type[2]);
		$display("and %0d unused codes over tickless and periodic modes, zero and full-range %s",
			reqs_by_type[3], "divisors");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
